[rtl/dsit_pkg.sv]
// shared types and constants for the descending sorted insert table
// no dependencies; every other rtl file imports this package
`default_nettype none

package dsit_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_BITS_DEF    = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] fruit_key;
    logic [9:0]  plot_row;
    logic [9:0]  plot_column;
    logic [7:0]  plot_tag;
    logic [5:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_key;
    logic [9:0]  out_row;
    logic [9:0]  out_column;
    logic [7:0]  out_tag;
    logic [6:0]  entry_total;
  } out_item_t;

  // non-key part of a stored entry
  typedef struct packed {
    logic [9:0] row;
    logic [9:0] column;
    logic [7:0] tag;
  } plot_info_t;

  localparam int INFO_W = $bits(plot_info_t);

endpackage

`default_nettype wire

[rtl/dsit_cell.sv]
// one table position: holds an entry and shifts or captures on insert
// depends on dsit_pkg
`default_nettype none

module dsit_cell #(
  parameter int KEY_BITS = dsit_pkg::KEY_BITS_DEF,
  parameter int CNT_W    = 7,
  parameter int IDX      = 0
) (
  input  wire logic                 clk,
  input  wire logic                 ins_en,
  input  wire logic [CNT_W-1:0]     count,
  input  wire logic [KEY_BITS-1:0]  new_key,
  input  wire dsit_pkg::plot_info_t new_info,
  input  wire logic [KEY_BITS-1:0]  left_key,
  input  wire dsit_pkg::plot_info_t left_info,
  input  wire logic                 left_gt,
  output logic [KEY_BITS-1:0]       key,
  output dsit_pkg::plot_info_t      info,
  output logic                      gt
);
  import dsit_pkg::*;

  logic [KEY_BITS-1:0] key_r;
  plot_info_t          info_r;
  logic                occupied;

  assign occupied = (CNT_W'(IDX) < count);
  // stored key strictly above the new one: this position stays put
  assign gt       = occupied && (key_r > new_key);

  always_ff @(posedge clk) begin
    if (ins_en && !gt) begin
      if (left_gt) begin
        key_r  <= new_key;
        info_r <= new_info;
      end else begin
        key_r  <= left_key;
        info_r <= left_info;
      end
    end
  end

  assign key  = key_r;
  assign info = info_r;

endmodule

`default_nettype wire

[rtl/dsit_readout.sv]
// two-level registered read select over the first 64 cells
// depends on dsit_pkg
`default_nettype none

module dsit_readout #(
  parameter int TABLE_DEPTH = dsit_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = dsit_pkg::KEY_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 load,
  input  wire logic [5:0]           idx,
  input  wire logic [KEY_BITS-1:0]  cell_key [TABLE_DEPTH],
  input  wire dsit_pkg::plot_info_t cell_info [TABLE_DEPTH],
  output logic [KEY_BITS-1:0]       rd_key,
  output dsit_pkg::plot_info_t      rd_info
);
  import dsit_pkg::*;

  localparam int EW = KEY_BITS + INFO_W;
  // a 6-bit index reaches at most 64 cells
  localparam int RD = (TABLE_DEPTH < 64) ? TABLE_DEPTH : 64;
  localparam int NG = (RD + 7) / 8;

  logic [EW-1:0] cand  [NG][8];
  logic [EW-1:0] grp_q [8];
  logic [2:0]    idx_hi_r;
  logic [EW-1:0] sel;

  for (genvar g = 0; g < NG; g++) begin : g_cand
    for (genvar j = 0; j < 8; j++) begin : g_lane
      if (g * 8 + j < RD) begin : g_on
        assign cand[g][j] = {cell_key[g * 8 + j], cell_info[g * 8 + j]};
      end else begin : g_off
        assign cand[g][j] = '0;
      end
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_grp
    if (g < NG) begin : g_live
      logic [EW-1:0] grp_r;
      always_ff @(posedge clk) begin
        if (load) begin
          grp_r <= cand[g][idx[2:0]];
        end
      end
      assign grp_q[g] = grp_r;
    end else begin : g_dead
      assign grp_q[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx_hi_r <= idx[5:3];
    end
  end

  assign sel     = grp_q[idx_hi_r];
  assign rd_key  = sel[EW-1:INFO_W];
  assign rd_info = plot_info_t'(sel[INFO_W-1:0]);

endmodule

`default_nettype wire

[rtl/descending_sorted_insert_table_top.sv]
// top level of the descending sorted insert table: cell chain, read select, control
// depends on dsit_pkg, dsit_cell, dsit_readout
//
//   channel | direction | payload      | handshake
//   in_     | input     | in_item_t    | in_valid / in_stall
//   out_    | output    | out_item_t   | out_valid / out_stall
//
// insert, clear and unused opcodes load the output register on acceptance; a read
// loads the registered two-level select over the cells, then the output register.
// all cells compare with the new key in the same cycle, then keep, capture or shift.
// rst_n (synchronous) empties the table; stored entries are not cleared.
// a result sits in the output register until taken; a new transaction is
// accepted while that register is free or being emptied and no read is pending,
// so the input stalls after each read until its result is loaded
`default_nettype none

module descending_sorted_insert_table_top #(
  parameter int TABLE_DEPTH = dsit_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = dsit_pkg::KEY_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dsit_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dsit_pkg::out_item_t     out_data
);
  import dsit_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IW    = (CNT_W > 6) ? CNT_W : 6;

  fsm_t              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              rd_bad_r;
  logic              out_load;
  logic              out_free;
  logic              accept;
  logic              ins_en;
  logic              rd_load;
  logic              full;
  logic              rd_bad;

  logic [KEY_BITS-1:0] new_key;
  plot_info_t          new_info;
  logic [KEY_BITS-1:0] cell_key  [TABLE_DEPTH];
  plot_info_t          cell_info [TABLE_DEPTH];
  logic                cell_gt   [TABLE_DEPTH];
  logic [KEY_BITS-1:0] rd_key;
  plot_info_t          rd_info;

  assign new_key  = KEY_BITS'(in_data.fruit_key);
  assign new_info = '{row: in_data.plot_row, column: in_data.plot_column,
                      tag: in_data.plot_tag};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      dsit_cell #(.KEY_BITS(KEY_BITS), .CNT_W(CNT_W), .IDX(i)) u_cell (
        .clk      (clk),
        .ins_en   (ins_en),
        .count    (count_r),
        .new_key  (new_key),
        .new_info (new_info),
        .left_key (new_key),
        .left_info(new_info),
        .left_gt  (1'b1),
        .key      (cell_key[i]),
        .info     (cell_info[i]),
        .gt       (cell_gt[i])
      );
    end else begin : g_body
      dsit_cell #(.KEY_BITS(KEY_BITS), .CNT_W(CNT_W), .IDX(i)) u_cell (
        .clk      (clk),
        .ins_en   (ins_en),
        .count    (count_r),
        .new_key  (new_key),
        .new_info (new_info),
        .left_key (cell_key[i-1]),
        .left_info(cell_info[i-1]),
        .left_gt  (cell_gt[i-1]),
        .key      (cell_key[i]),
        .info     (cell_info[i]),
        .gt       (cell_gt[i])
      );
    end
  end

  dsit_readout #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS)) u_readout (
    .clk      (clk),
    .load     (rd_load),
    .idx      (in_data.read_index),
    .cell_key (cell_key),
    .cell_info(cell_info),
    .rd_key   (rd_key),
    .rd_info  (rd_info)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r >= CNT_W'(TABLE_DEPTH));
  assign rd_bad   = (IW'(in_data.read_index) >= IW'(count_r));

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ins_en       = 1'b0;
    rd_load      = 1'b0;
    out_load     = 1'b0;
    out_data_nxt = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.opcode)
            OP_INSERT: begin
              out_load = 1'b1;
              if (full) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                ins_en    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_READ: begin
              rd_load   = 1'b1;
              state_nxt = S_READ;
            end
            OP_CLEAR: begin
              out_load  = 1'b1;
              count_nxt = '0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
          out_data_nxt.entry_total = 7'(count_nxt);
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (rd_bad_r) begin
            out_data_nxt.status = ST_RANGE;
          end else begin
            out_data_nxt.out_key    = 16'(rd_key);
            out_data_nxt.out_row    = rd_info.row;
            out_data_nxt.out_column = rd_info.column;
            out_data_nxt.out_tag    = rd_info.tag;
          end
          out_data_nxt.entry_total = 7'(count_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
    if (rd_load) begin
      rd_bad_r <= rd_bad;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
